// ===== hw/rtl/affine_rect_bounding_box_macros.svh =====
// ----------------------------------------------------------------------------
// affine_rect_bounding_box_macros
// Assertion macros for the affine bounding box block; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef AFFINE_RECT_BOUNDING_BOX_MACROS_SVH
`define AFFINE_RECT_BOUNDING_BOX_MACROS_SVH

`ifndef SYNTHESIS
`define ARBB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ARBB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ARBB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ARBB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/arbb_pkg.sv =====
// ----------------------------------------------------------------------------
// arbb_pkg
// Shared widths, register indexes and control types of the bounding box block.
// ----------------------------------------------------------------------------
package arbb_pkg;

  localparam int COORD_W    = 31;
  localparam int COEF_W     = 32;
  localparam int OUT_W      = 32;
  localparam int PROD_W     = COEF_W + COORD_W;
  localparam int ACC_W      = 64;
  localparam int IDX_W      = 3;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 128;
  localparam int NUM_STAGES = 6;

  typedef enum logic [IDX_W-1:0] {
    REG_SCALE_X = 3'd0,
    REG_SCALE_Y = 3'd1,
    REG_SKEW_YX = 3'd2,
    REG_SKEW_XY = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] scale_x;
    logic signed [COEF_W-1:0] scale_y;
    logic signed [COEF_W-1:0] skew_yx;
    logic signed [COEF_W-1:0] skew_xy;
    logic signed [COEF_W-1:0] shift_x;
    logic signed [COEF_W-1:0] shift_y;
  } cfg_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctl_t;

endpackage

// ===== hw/rtl/arbb_cfg.sv =====
// ----------------------------------------------------------------------------
// arbb_cfg
// Affine matrix register file written through the configuration channel.
// ----------------------------------------------------------------------------
module arbb_cfg
  import arbb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0] cfg_data,
  output cfg_t             cfg
);

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_SCALE_X: cfg_nxt.scale_x = cfg_data;
        REG_SCALE_Y: cfg_nxt.scale_y = cfg_data;
        REG_SKEW_YX: cfg_nxt.skew_yx = cfg_data;
        REG_SKEW_XY: cfg_nxt.skew_xy = cfg_data;
        REG_SHIFT_X: cfg_nxt.shift_x = cfg_data;
        REG_SHIFT_Y: cfg_nxt.shift_y = cfg_data;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_x <= COEF_ONE;
      cfg_r.scale_y <= COEF_ONE;
      cfg_r.skew_yx <= '0;
      cfg_r.skew_xy <= '0;
      cfg_r.shift_x <= '0;
      cfg_r.shift_y <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hw/rtl/arbb_flow.sv =====
// ----------------------------------------------------------------------------
// arbb_flow
// Valid bits and per-stage load enables; bubbles collapse under back-pressure.
// ----------------------------------------------------------------------------
module arbb_flow
  import arbb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output pipe_ctl_t ctl
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES:0]   rdy;

  always_comb begin
    rdy[NUM_STAGES] = out_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
    valid_nxt[0] = rdy[0] ? in_tvalid : valid_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_nxt[k] = rdy[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = valid_r[NUM_STAGES-1];
  assign ctl.load   = rdy[NUM_STAGES-1:0];
  assign ctl.valid  = valid_r;

endmodule

// ===== hw/rtl/arbb_axis_pipe.sv =====
// ----------------------------------------------------------------------------
// arbb_axis_pipe
// One output axis: products, per-term min/max, sum, truncation, saturation.
// ----------------------------------------------------------------------------
module arbb_axis_pipe
  import arbb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  pipe_ctl_t                ctl,
  input  logic signed [COEF_W-1:0] coef_u,
  input  logic signed [COEF_W-1:0] coef_v,
  input  logic signed [COEF_W-1:0] shift,
  input  logic signed [COORD_W-1:0] u_lo,
  input  logic signed [COORD_W-1:0] u_hi,
  input  logic signed [COORD_W-1:0] v_lo,
  input  logic signed [COORD_W-1:0] v_hi,
  output logic [OUT_W-1:0]         bound_lo,
  output logic [OUT_W-1:0]         bound_hi
);

  localparam int Q_W = ACC_W - FRAC_BITS;

  logic signed [PROD_W-1:0] pu_lo_r, pu_hi_r, pv_lo_r, pv_hi_r;
  logic signed [PROD_W-1:0] u_min_r, u_max_r, v_min_r, v_max_r;
  logic signed [ACC_W-1:0]  sum_lo_r, sum_hi_r;
  logic signed [Q_W-1:0]    q_lo_r, q_hi_r;
  logic [OUT_W-1:0]         sat_lo_r, sat_hi_r;

  logic signed [ACC_W-1:0]  shift_term;
  logic [ACC_W-1:0]         bias_lo, bias_hi;
  logic [ACC_W-1:0]         adj_lo, adj_hi;

  function automatic logic [OUT_W-1:0] saturate(input logic signed [Q_W-1:0] q);
    logic fits;
    fits = (&q[Q_W-1:OUT_W-1]) || !(|q[Q_W-1:OUT_W-1]);
    if (fits) begin
      saturate = q[OUT_W-1:0];
    end else if (q[Q_W-1]) begin
      saturate = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      saturate = {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  assign shift_term = ACC_W'(signed'({shift, {FRAC_BITS{1'b0}}}));
  assign bias_lo    = {{Q_W{1'b0}}, {FRAC_BITS{sum_lo_r[ACC_W-1]}}};
  assign bias_hi    = {{Q_W{1'b0}}, {FRAC_BITS{sum_hi_r[ACC_W-1]}}};
  assign adj_lo     = sum_lo_r + bias_lo;
  assign adj_hi     = sum_hi_r + bias_hi;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      pu_lo_r <= PROD_W'(coef_u) * PROD_W'(u_lo);
      pu_hi_r <= PROD_W'(coef_u) * PROD_W'(u_hi);
      pv_lo_r <= PROD_W'(coef_v) * PROD_W'(v_lo);
      pv_hi_r <= PROD_W'(coef_v) * PROD_W'(v_hi);
    end
    if (ctl.load[2]) begin
      u_min_r <= (pu_lo_r < pu_hi_r) ? pu_lo_r : pu_hi_r;
      u_max_r <= (pu_lo_r < pu_hi_r) ? pu_hi_r : pu_lo_r;
      v_min_r <= (pv_lo_r < pv_hi_r) ? pv_lo_r : pv_hi_r;
      v_max_r <= (pv_lo_r < pv_hi_r) ? pv_hi_r : pv_lo_r;
    end
    if (ctl.load[3]) begin
      sum_lo_r <= ACC_W'(u_min_r) + ACC_W'(v_min_r) + shift_term;
      sum_hi_r <= ACC_W'(u_max_r) + ACC_W'(v_max_r) + shift_term;
    end
    if (ctl.load[4]) begin
      q_lo_r <= adj_lo[ACC_W-1:FRAC_BITS];
      q_hi_r <= adj_hi[ACC_W-1:FRAC_BITS];
    end
    if (ctl.load[5]) begin
      sat_lo_r <= saturate(q_lo_r);
      sat_hi_r <= saturate(q_hi_r);
    end
  end

  assign bound_lo = sat_lo_r;
  assign bound_hi = sat_hi_r;

endmodule

// ===== hw/rtl/affine_rect_bounding_box.sv =====
// ----------------------------------------------------------------------------
// affine_rect_bounding_box
// Maps a rectangle through a 2x3 fixed-point affine matrix and returns the
// axis-aligned bounding box of the mapped corners.
//
//   Channel  Direction  Payload
//   in_      sink       rect_x_lo, rect_x_hi, rect_y_lo, rect_y_hi (31b each)
//   out_     source     bound_x_lo, bound_x_hi, bound_y_lo, bound_y_hi (32b)
//   cfg_     sink       register index (3b), register value (32b)
//
// One rectangle per cycle while the output is not stalled; six-stage datapath
// (capture, multiply, min/max, sum, truncate, saturate).
// Reset clears the valid bits and loads the identity matrix.
// A stall holds only the stages that are full; empty stages keep filling.
// Configuration writes are registered and always accepted.
// ----------------------------------------------------------------------------
`include "affine_rect_bounding_box_macros.svh"

module affine_rect_bounding_box
  import arbb_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // rect_x_lo[30:0], rect_x_hi[61:31], rect_y_lo[92:62], rect_y_hi[123:93]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // bound_x_lo[31:0], bound_x_hi[63:32], bound_y_lo[95:64], bound_y_hi[127:96]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [COEF_W-1:0]     cfg_data
);

  cfg_t      cfg;
  pipe_ctl_t ctl;

  logic signed [COORD_W-1:0] x_lo_r, x_hi_r, y_lo_r, y_hi_r;
  logic [OUT_W-1:0] bx_lo, bx_hi, by_lo, by_hi;

  arbb_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  arbb_flow u_flow (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      x_lo_r <= in_tdata[COORD_W-1:0];
      x_hi_r <= in_tdata[2*COORD_W-1:COORD_W];
      y_lo_r <= in_tdata[3*COORD_W-1:2*COORD_W];
      y_hi_r <= in_tdata[4*COORD_W-1:3*COORD_W];
    end
  end

  arbb_axis_pipe #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk      (clk),
    .ctl      (ctl),
    .coef_u   (cfg.scale_x),
    .coef_v   (cfg.skew_xy),
    .shift    (cfg.shift_x),
    .u_lo     (x_lo_r),
    .u_hi     (x_hi_r),
    .v_lo     (y_lo_r),
    .v_hi     (y_hi_r),
    .bound_lo (bx_lo),
    .bound_hi (bx_hi)
  );

  arbb_axis_pipe #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk      (clk),
    .ctl      (ctl),
    .coef_u   (cfg.skew_yx),
    .coef_v   (cfg.scale_y),
    .shift    (cfg.shift_y),
    .u_lo     (x_lo_r),
    .u_hi     (x_hi_r),
    .v_lo     (y_lo_r),
    .v_hi     (y_hi_r),
    .bound_lo (by_lo),
    .bound_hi (by_hi)
  );

  assign out_tdata = {by_hi, by_lo, bx_hi, bx_lo};

  `ARBB_ASSERT_IMP(a_sink_ready_frees_input, clk, rst_n, out_tready, in_tready)
  `ARBB_ASSERT_NXT(a_accept_fills_capture, clk, rst_n, in_tvalid && in_tready, ctl.valid[0])
  `ARBB_ASSERT_IMP(a_x_ordered, clk, rst_n, out_tvalid, signed'(bx_lo) <= signed'(bx_hi))
  `ARBB_ASSERT_IMP(a_y_ordered, clk, rst_n, out_tvalid, signed'(by_lo) <= signed'(by_hi))

endmodule

// ===== dv/tb_affine_rect_bounding_box.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_affine_rect_bounding_box
// Self-checking bench for the affine bounding box block. Rectangles are driven
// on the input stream from a queue. Each accepted transaction is mapped
// through a local copy of the matrix to predict its bounding box. A monitor
// compares every output transaction field by field with the oldest
// prediction. The run covers identity, saturating, truncating and random
// matrices, with random gaps, random stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_affine_rect_bounding_box;
  import arbb_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 50;

  localparam logic [IDX_W-1:0] IDX_UNUSED_LO = 3'd6;
  localparam logic [IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // packed from the top down, so x_lo lands in the lowest bits
  typedef struct packed {
    coord_t y_hi;
    coord_t y_lo;
    coord_t x_hi;
    coord_t x_lo;
  } rect_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] y_hi;
    logic signed [OUT_W-1:0] y_lo;
    logic signed [OUT_W-1:0] x_hi;
    logic signed [OUT_W-1:0] x_lo;
  } bound_t;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t UNITY = coef_t'(1) <<< FRAC_BITS;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // rect_x_lo[30:0], rect_x_hi[61:31], rect_y_lo[92:62], rect_y_hi[123:93]
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // bound_x_lo[31:0], bound_x_hi[63:32], bound_y_lo[95:64], bound_y_hi[127:96]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [COEF_W-1:0]     cfg_data = '0;

  cfg_t   matrix;
  rect_t  rect_queue[$];
  bound_t bound_queue[$];
  int     pending_items = 0;
  int     err_count = 0;
  int     quiet_cycles = 0;
  logic   in_gaps_on = 1'b0;
  logic   out_stalls_on = 1'b0;
  logic   long_hold_req = 1'b0;

  affine_rect_bounding_box #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // exact fixed-point map of one coordinate, truncated toward zero, saturated
  function automatic longint map_axis(longint a, longint x, longint b, longint y,
                                      longint t);
    longint one;
    longint acc;
    longint q;
    one = longint'(1) <<< FRAC_BITS;
    acc = a * x + b * y + t * one;
    q = acc / one;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q;
  endfunction

  function automatic bound_t predict_bounds(rect_t r);
    longint x, y, px, py;
    longint xmin, xmax, ymin, ymax;
    bound_t b;
    xmin = 0;
    xmax = 0;
    ymin = 0;
    ymax = 0;
    for (int i = 0; i < 4; i++) begin
      x = i[0] ? r.x_hi : r.x_lo;
      y = i[1] ? r.y_hi : r.y_lo;
      px = map_axis(matrix.scale_x, x, matrix.skew_xy, y, matrix.shift_x);
      py = map_axis(matrix.skew_yx, x, matrix.scale_y, y, matrix.shift_y);
      if (i == 0 || px < xmin) xmin = px;
      if (i == 0 || px > xmax) xmax = px;
      if (i == 0 || py < ymin) ymin = py;
      if (i == 0 || py > ymax) ymax = py;
    end
    b.x_lo = xmin[OUT_W-1:0];
    b.x_hi = xmax[OUT_W-1:0];
    b.y_lo = ymin[OUT_W-1:0];
    b.y_hi = ymax[OUT_W-1:0];
    return b;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3, 4, 5: return coord_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(0, 7))
      0: return COEF_MIN;
      1: return COEF_MAX;
      2: return '0;
      3: return $urandom_range(0, 1) ? UNITY : -UNITY;
      4, 5: return coef_t'(int'($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
      default: return coef_t'($urandom);
    endcase
  endfunction

  function automatic void push_rect(coord_t xl, coord_t xh, coord_t yl, coord_t yh);
    rect_t r;
    r.x_lo = xl;
    r.x_hi = xh;
    r.y_lo = yl;
    r.y_hi = yh;
    rect_queue.push_back(r);
    pending_items++;
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input coef_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SCALE_X: matrix.scale_x = val;
      REG_SCALE_Y: matrix.scale_y = val;
      REG_SKEW_YX: matrix.skew_yx = val;
      REG_SKEW_XY: matrix.skew_xy = val;
      REG_SHIFT_X: matrix.shift_x = val;
      REG_SHIFT_Y: matrix.shift_y = val;
      default: ;
    endcase
  endtask

  task automatic write_matrix(coef_t sx, coef_t sy, coef_t kyx, coef_t kxy,
                              coef_t tx, coef_t ty);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_SKEW_YX, kyx);
    write_reg(REG_SKEW_XY, kxy);
    write_reg(REG_SHIFT_X, tx);
    write_reg(REG_SHIFT_Y, ty);
  endtask

  task automatic wait_drained();
    while (pending_items != 0 || bound_queue.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    rect_t r;
    int gap_left;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        r = in_tdata[$bits(rect_t)-1:0];
        bound_queue.push_back(predict_bounds(r));
        pending_items--;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (rect_queue.size() != 0) begin
          in_tdata  <= {{(IN_DATA_W - $bits(rect_t)){1'b0}}, rect_queue.pop_front()};
          in_tvalid <= 1'b1;
          if (in_gaps_on) gap_left = idle_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk) begin
    bound_t got;
    bound_t want;
    int hold_left;
    int len;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (bound_queue.size() == 0) begin
          $error("unexpected output transaction: %h", out_tdata);
          err_count++;
        end else begin
          want = bound_queue.pop_front();
          if (got.x_lo !== want.x_lo) begin
            $error("bound_x_lo: expected %0d, got %0d", want.x_lo, got.x_lo);
            err_count++;
          end
          if (got.x_hi !== want.x_hi) begin
            $error("bound_x_hi: expected %0d, got %0d", want.x_hi, got.x_hi);
            err_count++;
          end
          if (got.y_lo !== want.y_lo) begin
            $error("bound_y_lo: expected %0d, got %0d", want.y_lo, got.y_lo);
            err_count++;
          end
          if (got.y_hi !== want.y_hi) begin
            $error("bound_y_hi: expected %0d, got %0d", want.y_hi, got.y_hi);
            err_count++;
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        hold_left = LONG_HOLD;
      end
      len = out_stalls_on ? idle_len() : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (len > 0) begin
        hold_left = len - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_affine_rect_bounding_box: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    matrix.scale_x = UNITY;
    matrix.scale_y = UNITY;
    matrix.skew_yx = '0;
    matrix.skew_xy = '0;
    matrix.shift_x = '0;
    matrix.shift_y = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity after reset: extremes and swapped edges
    push_rect('0, '0, '0, '0);
    push_rect(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    push_rect(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    push_rect(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    push_rect(COORD_MAX, COORD_MIN, coord_t'(5), coord_t'(-5));
    wait_drained();

    // largest coefficients: saturate both ways
    write_matrix(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    push_rect(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    push_rect(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    push_rect('0, '0, '0, '0);
    wait_drained();

    write_matrix(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    push_rect(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    push_rect(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    push_rect(COORD_MIN, COORD_MAX, coord_t'(1), coord_t'(-1));
    wait_drained();

    // fractional coefficients: truncation toward zero on negative values
    write_matrix(UNITY >>> 1, -(UNITY >>> 1), UNITY >>> 2, -(UNITY >>> 2),
                 coef_t'(7), coef_t'(-7));
    write_reg(IDX_UNUSED_LO, coef_t'($urandom));
    write_reg(IDX_UNUSED_HI, coef_t'($urandom));
    push_rect(coord_t'(-3), coord_t'(3), coord_t'(-1), coord_t'(1));
    push_rect(coord_t'(1), coord_t'(1), coord_t'(1), coord_t'(1));
    push_rect(coord_t'(-1), coord_t'(-1), coord_t'(-1), coord_t'(-1));
    push_rect(coord_t'(9), coord_t'(-9), coord_t'(5), coord_t'(-5));
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_matrix(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                   rand_coef(), rand_coef());
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? IDX_UNUSED_LO : IDX_UNUSED_HI, coef_t'($urandom));
      @(posedge clk);
      if (ph == 5) begin
        // hold off the output so the pipeline backs up into the input
        in_gaps_on    <= 1'b0;
        out_stalls_on <= 1'b0;
        long_hold_req <= 1'b1;
      end else begin
        in_gaps_on    <= (ph % 4 != 0);
        out_stalls_on <= (ph % 4 != 0);
      end
      for (int n = 0; n < PHASE_ITEMS; n++)
        push_rect(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      wait_drained();
    end

    if (err_count == 0 && bound_queue.size() == 0) begin
      $display("tb_affine_rect_bounding_box: done, clean");
    end else begin
      $display("tb_affine_rect_bounding_box: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/arbb_pkg.sv
hw/rtl/arbb_cfg.sv
hw/rtl/arbb_flow.sv
hw/rtl/arbb_axis_pipe.sv
hw/rtl/affine_rect_bounding_box.sv
dv/tb_affine_rect_bounding_box.sv
